// ----- rtl/core/transfer_ring_producer_assert.svh -----
// ----------------------------------------------------------------------------
// Transfer ring producer assertion macros
// Short forms for the concurrent checks of the transfer ring producer.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_RING_PRODUCER_ASSERT_SVH
`define TRANSFER_RING_PRODUCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TRP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transfer ring producer check failed");

// Next-cycle implication, disabled while reset is high.
`define TRP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transfer ring producer check failed");

`endif

// ----- rtl/core/trp_pkg.sv -----
// ----------------------------------------------------------------------------
// Transfer ring producer package
// Result kinds, operation codes, control word bits and shared adder types.
// ----------------------------------------------------------------------------
package trp_pkg;

   typedef enum logic [2:0] {
      KIND_PREWRITE  = 3'd0,
      KIND_PUBLISH   = 3'd1,
      KIND_REJECT    = 3'd2,
      KIND_RETIRE_OK = 3'd3,
      KIND_UNDERFLOW = 3'd4
   } kind_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RETIRE = 1'b1;

   localparam int unsigned CTL_CYCLE_BIT = 0;
   localparam int unsigned CTL_CHAIN_BIT = 4;
   localparam logic [31:0] CTL_CHAIN     = 32'h0000_0010;
   localparam logic [31:0] LINK_CTL      = 32'h0000_1802;
   localparam logic [5:0]  DROP_LIMIT    = 6'd63;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_req_type;

   typedef struct packed {
      logic        carry;
      logic [31:0] sum;
   } alu_rsp_type;

endpackage

// ----- rtl/core/trp_alu.sv -----
// ----------------------------------------------------------------------------
// Transfer ring producer shared adder
// One 32-bit add/subtract unit with carry out, shared by address generation,
// the space check, the used count update and retire.
// ----------------------------------------------------------------------------
module trp_alu
   import trp_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [31:0] b_eff;
   logic [32:0] total;

   assign b_eff = req.sub ? ~req.b : req.b;
   assign total = {1'b0, req.a} + {1'b0, b_eff} + {32'd0, req.sub};
   assign rsp.carry = total[32];
   assign rsp.sum   = total[31:0];

endmodule

// ----- rtl/core/transfer_ring_producer.sv -----
// ----------------------------------------------------------------------------
// Transfer ring producer
// Producer side of a cycle-bit transfer ring: prewrites descriptors with an
// inverted cycle bit, inserts the link descriptor at the ring end, publishes
// the true control words in reverse order and tracks ring occupancy.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Beat
//   req_     in         req_valid/req_stall one load or retire item
//   rsp_     out        rsp_valid/rsp_stall one ring write or status result
//   csr_     in         csr_valid/csr_ready ring base address
//
// Retire, rejected and swallowed items pass S_DECODE only; an accepted descriptor
// passes S_DECODE and S_WRITE, plus S_LINK when the link descriptor is inserted.
// The last descriptor of a transfer adds S_SUM, then S_PUB_RD and S_PUB per entry.
// All results go through one shared adder, one result per emitting step.
// Reset is synchronous and clears control state; the pending store needs none.
// rsp_stall holds the sequencer on its emitting step until the output is free.
module transfer_ring_producer
   import trp_pkg::*;
#(
   parameter int unsigned RING_SLOTS = 256,
   parameter int unsigned MAX_TD     = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_trb_parameter,
   input  logic [31:0] req_trb_status,
   input  logic [31:0] req_trb_control,
   input  logic [5:0]  req_td_length,
   input  logic [7:0]  req_retire_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_ring_slot,
   output logic [63:0] rsp_write_parameter,
   output logic [31:0] rsp_write_status,
   output logic [31:0] rsp_write_control,
   output logic [31:0] rsp_entry_address,
   output logic        rsp_is_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_ring_base
);

   localparam int unsigned SLOT_W     = $clog2(RING_SLOTS);
   localparam int unsigned PEND_DEPTH = MAX_TD + 1;
   localparam int unsigned IDX_W      = $clog2(PEND_DEPTH);
   localparam int unsigned CNT_W      = $clog2(PEND_DEPTH + 1);
   localparam int unsigned PEND_W     = SLOT_W + 32;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);
   localparam logic [31:0]       USED_MAX  = 32'(RING_SLOTS - 1);
   localparam logic [CNT_W-1:0]  PEND_FULL = CNT_W'(PEND_DEPTH);
   localparam logic [5:0]        TD_MAX    = 6'(MAX_TD);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b000_0001,
      S_DECODE = 7'b000_0010,
      S_LINK   = 7'b000_0100,
      S_WRITE  = 7'b000_1000,
      S_SUM    = 7'b001_0000,
      S_PUB_RD = 7'b010_0000,
      S_PUB    = 7'b100_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] base_ff, base_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] used_ff, used_in;
   logic        cycle_ff, cycle_in;
   logic [5:0]  pos_ff, pos_in;
   logic        drop_ff, drop_in;
   logic        prev_chain_ff, prev_chain_in;
   logic [CNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   logic        op_ff, op_in;
   logic [63:0] param_ff, param_in;
   logic [31:0] status_ff, status_in;
   logic [31:0] ctl_ff, ctl_in;
   logic [5:0]  len_ff, len_in;
   logic [7:0]  rcount_ff, rcount_in;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_slot_ff, rsp_slot_in;
   logic [63:0] rsp_param_ff, rsp_param_in;
   logic [31:0] rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_ctl_ff, rsp_ctl_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [PEND_W-1:0] pend_mem_ff [PEND_DEPTH];
   logic [PEND_W-1:0] pend_rd_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [PEND_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] rd_slot;
   logic [31:0]       rd_ctl;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic        out_free;
   logic        emit;
   kind_type    e_kind;
   logic [SLOT_W-1:0] e_slot;
   logic [SLOT_W+7:0] e_slot_ext;
   logic [63:0] e_param;
   logic [31:0] e_status;
   logic [31:0] e_ctl;
   logic        e_last;
   logic [SLOT_W-1:0] addr_slot;
   logic [6:0]  pos_inc;
   logic        reject;
   logic        td_end;
   logic [31:0] flags;
   logic [31:0] lflags;

   trp_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign rd_addr = IDX_W'(pend_cnt_ff - CNT_W'(1));
   assign rd_slot = pend_rd_ff[PEND_W-1:32];
   assign rd_ctl  = pend_rd_ff[31:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos_inc = {1'b0, pos_ff} + 7'd1;
   assign e_slot_ext = {8'd0, e_slot};

   always_comb begin
      state_in      = state_ff;
      base_in       = csr_valid ? csr_ring_base : base_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      cycle_in      = cycle_ff;
      pos_in        = pos_ff;
      drop_in       = drop_ff;
      prev_chain_in = prev_chain_ff;
      pend_cnt_in   = pend_cnt_ff;
      op_in         = op_ff;
      param_in      = param_ff;
      status_in     = status_ff;
      ctl_in        = ctl_ff;
      len_in        = len_ff;
      rcount_in     = rcount_ff;

      alu_req   = '0;
      addr_slot = tail_ff;
      emit      = 1'b0;
      e_kind    = KIND_PREWRITE;
      e_slot    = '0;
      e_param   = '0;
      e_status  = '0;
      e_ctl     = '0;
      e_last    = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = '0;
      reject    = 1'b0;
      td_end    = 1'b0;
      flags     = {ctl_ff[31:1], cycle_ff};
      lflags    = LINK_CTL | {31'd0, cycle_ff} |
                  ((pos_ff != 6'd0 && prev_chain_ff) ? CTL_CHAIN : 32'd0);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               param_in  = req_trb_parameter;
               status_in = req_trb_status;
               ctl_in    = req_trb_control;
               len_in    = req_td_length;
               rcount_in = req_retire_count;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (op_ff == OP_RETIRE) begin
               alu_req.a   = 32'(used_ff);
               alu_req.b   = 32'(rcount_ff);
               alu_req.sub = 1'b1;
               if (out_free) begin
                  emit     = 1'b1;
                  e_last   = 1'b1;
                  e_kind   = alu_rsp.carry ? KIND_RETIRE_OK : KIND_UNDERFLOW;
                  used_in  = alu_rsp.carry ? alu_rsp.sum[SLOT_W-1:0] : '0;
                  state_in = S_IDLE;
               end
            end else if (drop_ff) begin
               if (pos_inc >= {1'b0, len_ff} || pos_inc >= {1'b0, DROP_LIMIT}) begin
                  drop_in = 1'b0;
                  pos_in  = '0;
               end else begin
                  pos_in = pos_inc[5:0];
               end
               state_in = S_IDLE;
            end else if (pos_ff == 6'd0) begin
               alu_req.a = 32'(used_ff);
               alu_req.b = 32'(len_ff);
               reject = (len_ff == 6'd0) || (len_ff > TD_MAX) || (alu_rsp.sum > USED_MAX);
               if (reject) begin
                  if (out_free) begin
                     emit   = 1'b1;
                     e_last = 1'b1;
                     e_kind = KIND_REJECT;
                     if (len_ff > 6'd1) begin
                        drop_in = 1'b1;
                        pos_in  = 6'd1;
                     end
                     state_in = S_IDLE;
                  end
               end else begin
                  pend_cnt_in   = '0;
                  prev_chain_in = 1'b0;
                  state_in      = (tail_ff >= LAST_SLOT) ? S_LINK : S_WRITE;
               end
            end else begin
               state_in = (tail_ff >= LAST_SLOT) ? S_LINK : S_WRITE;
            end
         end
         S_LINK: begin
            addr_slot = LAST_SLOT;
            alu_req.a = base_ff;
            alu_req.b = 32'({addr_slot, 4'b0000});
            if (out_free) begin
               emit     = 1'b1;
               e_slot   = LAST_SLOT;
               e_param  = {32'd0, base_ff};
               e_ctl    = lflags ^ 32'(1 << CTL_CYCLE_BIT);
               if (pend_cnt_ff < PEND_FULL) begin
                  mem_we      = 1'b1;
                  mem_wdata   = {LAST_SLOT, lflags};
                  pend_cnt_in = pend_cnt_ff + CNT_W'(1);
               end
               tail_in  = '0;
               cycle_in = !cycle_ff;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            alu_req.a = base_ff;
            alu_req.b = 32'({addr_slot, 4'b0000});
            if (out_free) begin
               td_end   = pos_inc >= {1'b0, len_ff} || pos_inc >= {1'b0, TD_MAX};
               emit     = 1'b1;
               e_slot   = tail_ff;
               e_param  = param_ff;
               e_status = status_ff;
               e_ctl    = flags ^ 32'(1 << CTL_CYCLE_BIT);
               e_last   = !td_end;
               if (pend_cnt_ff < PEND_FULL) begin
                  mem_we      = 1'b1;
                  mem_wdata   = {tail_ff, flags};
                  pend_cnt_in = pend_cnt_ff + CNT_W'(1);
               end
               tail_in       = tail_ff + SLOT_W'(1);
               prev_chain_in = ctl_ff[CTL_CHAIN_BIT];
               pos_in        = pos_inc[5:0];
               state_in      = td_end ? S_SUM : S_IDLE;
            end
         end
         S_SUM: begin
            alu_req.a     = 32'(used_ff);
            alu_req.b     = 32'(pos_ff);
            used_in       = (alu_rsp.sum > USED_MAX) ? LAST_SLOT : alu_rsp.sum[SLOT_W-1:0];
            pos_in        = '0;
            prev_chain_in = 1'b0;
            state_in      = S_PUB_RD;
         end
         S_PUB_RD: begin
            state_in = S_PUB;
         end
         S_PUB: begin
            addr_slot = rd_slot;
            alu_req.a = base_ff;
            alu_req.b = 32'({addr_slot, 4'b0000});
            if (out_free) begin
               emit        = 1'b1;
               e_kind      = KIND_PUBLISH;
               e_slot      = rd_slot;
               e_ctl       = rd_ctl;
               e_last      = (pend_cnt_ff == CNT_W'(1));
               pend_cnt_in = pend_cnt_ff - CNT_W'(1);
               state_in    = e_last ? S_IDLE : S_PUB_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_param_in  = rsp_param_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ctl_in    = rsp_ctl_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = e_kind;
         rsp_slot_in   = e_slot_ext[7:0];
         rsp_param_in  = e_param;
         rsp_status_in = e_status;
         rsp_ctl_in    = e_ctl;
         rsp_addr_in   = (e_kind == KIND_PREWRITE || e_kind == KIND_PUBLISH) ?
                         alu_rsp.sum : 32'd0;
         rsp_last_in   = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         tail_ff       <= '0;
         used_ff       <= '0;
         cycle_ff      <= 1'b1;
         pos_ff        <= '0;
         drop_ff       <= 1'b0;
         prev_chain_ff <= 1'b0;
         pend_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         tail_ff       <= tail_in;
         used_ff       <= used_in;
         cycle_ff      <= cycle_in;
         pos_ff        <= pos_in;
         drop_ff       <= drop_in;
         prev_chain_ff <= prev_chain_in;
         pend_cnt_ff   <= pend_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      param_ff      <= param_in;
      status_ff     <= status_in;
      ctl_ff        <= ctl_in;
      len_ff        <= len_in;
      rcount_ff     <= rcount_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_param_ff  <= rsp_param_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ctl_ff    <= rsp_ctl_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pend_mem_ff[pend_cnt_ff[IDX_W-1:0]] <= mem_wdata;
      end
      pend_rd_ff <= pend_mem_ff[rd_addr];
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_ring_slot       = rsp_slot_ff;
   assign rsp_write_parameter = rsp_param_ff;
   assign rsp_write_status    = rsp_status_ff;
   assign rsp_write_control   = rsp_ctl_ff;
   assign rsp_entry_address   = rsp_addr_ff;
   assign rsp_is_last         = rsp_last_ff;

endmodule

// ----- rtl/core/trp_checker.sv -----
// ----------------------------------------------------------------------------
// Transfer ring producer port checker
// Watches the top-level ports of the transfer ring producer over time.
// ----------------------------------------------------------------------------
`include "transfer_ring_producer_assert.svh"

module trp_checker
   import trp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_ring_slot,
   input logic [63:0] rsp_write_parameter,
   input logic [31:0] rsp_write_status,
   input logic [31:0] rsp_write_control,
   input logic [31:0] rsp_entry_address,
   input logic        rsp_is_last
);

   logic         rsp_held;
   logic         req_taken;
   logic         status_beat;
   logic         status_clean;
   logic         publish_beat;
   logic         publish_clean;
   logic [171:0] rsp_payload;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign req_taken     = req_valid && !req_stall;
   assign status_beat   = rsp_valid && (rsp_kind == KIND_REJECT ||
                          rsp_kind == KIND_RETIRE_OK || rsp_kind == KIND_UNDERFLOW);
   assign status_clean  = rsp_is_last && rsp_ring_slot == 8'd0 &&
                          rsp_entry_address == 32'd0 && rsp_write_control == 32'd0;
   assign publish_beat  = rsp_valid && rsp_kind == KIND_PUBLISH;
   assign publish_clean = rsp_write_parameter == 64'd0 && rsp_write_status == 32'd0;
   assign rsp_payload   = {rsp_kind, rsp_ring_slot, rsp_write_parameter, rsp_write_status,
                           rsp_write_control, rsp_entry_address, rsp_is_last};

   // A stalled result beat keeps its contents.
   `TRP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // The sequencer is busy on the cycle after it takes an item.
   `TRP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_taken, req_stall)

   // Status results end their item and carry no ring write.
   `TRP_ASSERT_IMP(a_status_last, clock, reset, status_beat, status_clean)

   // A publish beat writes only a control word.
   `TRP_ASSERT_IMP(a_publish_words, clock, reset, publish_beat, publish_clean)

endmodule

bind transfer_ring_producer trp_checker u_trp_checker (.*);
